FILE: hw/rtl/rf_remote_pulse_code_decoder_top_macros.svh
// Assertion macros for the pulse-code decoder RTL.
// Used by rf_remote_pulse_code_decoder_top; expects clock and reset in scope.
`ifndef RF_REMOTE_PULSE_CODE_DECODER_TOP_MACROS_SVH
`define RF_REMOTE_PULSE_CODE_DECODER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define RFPCD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define RFPCD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/rfpcd_pkg.sv
// Shared constants for the pulse-code radio remote decoder.
// No dependencies; imported by rf_remote_pulse_code_decoder_top.
package rfpcd_pkg;

   // default code / data lengths
   localparam int CODE_BITS_DEF = 24;
   localparam int DATA_BITS_DEF = 8;

   // request / response widths
   localparam int REQ_DATA_W = 32;   // high_time, low_time
   localparam int REQ_USER_W = 2;    // op
   localparam int RSP_DATA_W = 48;   // 44 bits of fields, zero padded
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam int TIME_W    = 16;
   localparam int COUNT_W   = 8;
   localparam int CODE_OUT_W = 24;
   localparam int DATA_OUT_W = 8;

   // op codes
   localparam logic [REQ_USER_W-1:0] OP_PULSE = 2'd0;
   localparam logic [REQ_USER_W-1:0] OP_TICK  = 2'd1;
   localparam logic [REQ_USER_W-1:0] OP_ACK   = 2'd2;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_SHORT_MIN      = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_SHORT_MAX      = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_LONG_MIN       = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_LONG_MAX       = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_SYNC_MIN       = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_SYNC_MAX       = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_REPEAT_TIMEOUT = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_LEARN_REPEATS  = 3'd7;

   // register reset values
   localparam logic [TIME_W-1:0]  SHORT_MIN_RST      = 16'd28;
   localparam logic [TIME_W-1:0]  SHORT_MAX_RST      = 16'd45;
   localparam logic [TIME_W-1:0]  LONG_MIN_RST       = 16'd84;
   localparam logic [TIME_W-1:0]  LONG_MAX_RST       = 16'd135;
   localparam logic [TIME_W-1:0]  SYNC_MIN_RST       = 16'd868;
   localparam logic [TIME_W-1:0]  SYNC_MAX_RST       = 16'd1395;
   localparam logic [TIME_W-1:0]  REPEAT_TIMEOUT_RST = 16'd22500;
   localparam logic [COUNT_W-1:0] LEARN_REPEATS_RST  = 8'd10;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;
   localparam logic [TIME_W-1:0]  TIMER_MAX = 16'hFFFF;

endpackage

FILE: hw/rtl/rf_remote_pulse_code_decoder_top.sv
// Pulse-width radio remote decoder: one request per cycle while responses are
// taken, two register stages. Depends on rfpcd_pkg and
// rf_remote_pulse_code_decoder_top_macros.svh.
// Takes one request per clock while rsp_tready is high (op in req_tuser: pulse
// pair, timer tick or acknowledge) and returns exactly one response per
// request, holding the flags, held code/data, repeat count and sync state after
// that request. A request is captured in an input register, and the decoder
// state and the response register are updated from it once the response
// register is empty or being taken; the input register takes one more request
// while a response waits. Threshold registers are to be written by the user
// through the csr_ port only while idle; the block does not enforce this.

`include "rf_remote_pulse_code_decoder_top_macros.svh"

module rf_remote_pulse_code_decoder_top #(
   parameter int CODE_BITS = rfpcd_pkg::CODE_BITS_DEF,
   parameter int DATA_BITS = rfpcd_pkg::DATA_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request: tdata = high_time[15:0], low_time[31:16]; tuser = op[1:0]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [rfpcd_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [rfpcd_pkg::REQ_USER_W-1:0]   req_tuser,
   // response: tdata = code_valid[0], data_valid[1], learn_valid[2],
   // held_code_out[26:3], held_data_out[34:27], repeats_out[42:35],
   // synced_out[43], zero[47:44]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [rfpcd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // register write port
   input  logic                               csr_we,
   input  logic [rfpcd_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [rfpcd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rfpcd_pkg::*;

   localparam logic [COUNT_W-1:0] CODE_END = COUNT_W'(CODE_BITS);
   localparam logic [COUNT_W-1:0] FULL_END = COUNT_W'(CODE_BITS + DATA_BITS);

   // config registers
   logic [TIME_W-1:0]  short_min_ff, short_max_ff, long_min_ff, long_max_ff;
   logic [TIME_W-1:0]  sync_min_ff, sync_max_ff, timeout_ff;
   logic [COUNT_W-1:0] learn_ff;

   // input stage
   logic              in_valid_ff;
   logic [1:0]        in_op_ff;
   logic [TIME_W-1:0] in_high_ff, in_low_ff;
   logic              advance;

   // decoder state
   logic                 synced_ff, synced_in;
   logic [COUNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [COUNT_W-1:0]   repeat_ff, repeat_in;
   logic [CODE_BITS-1:0] code_shift_ff, code_shift_in;
   logic [DATA_BITS-1:0] data_shift_ff, data_shift_in;
   logic [CODE_BITS-1:0] held_code_ff, held_code_in;
   logic [DATA_BITS-1:0] held_data_ff, held_data_in;
   logic                 flag_code_ff, flag_code_in;
   logic                 flag_data_ff, flag_data_in;
   logic                 flag_learn_ff, flag_learn_in;
   logic [TIME_W-1:0]    timer_ff, timer_in;

   // output stage
   logic                  out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;

   // decode helpers
   logic                 hs, ls, is_sync, bit0, bit1, with_data, first_pkt, pkt_match;
   logic [CODE_BITS-1:0] hc1;
   logic [DATA_BITS-1:0] hd1;
   logic [COUNT_W-1:0]   rc1, rc2;
   logic [TIME_W-1:0]    timer_tick;
   logic [31:0]          held_code_ext;
   logic [15:0]          held_data_ext;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // window compares, all strict
   assign hs      = (in_high_ff > short_min_ff) && (in_high_ff < short_max_ff);
   assign ls      = (in_low_ff > short_min_ff) && (in_low_ff < short_max_ff);
   assign is_sync = hs && (in_low_ff > sync_min_ff) && (in_low_ff < sync_max_ff);
   assign bit0    = hs && (in_low_ff > long_min_ff) && (in_low_ff < long_max_ff);
   assign bit1    = ls && (in_high_ff > long_min_ff) && (in_high_ff < long_max_ff);

   // end-of-packet bookkeeping
   assign with_data = (bit_cnt_ff == FULL_END);
   assign first_pkt = (repeat_ff == '0);
   assign hc1       = first_pkt ? code_shift_ff : held_code_ff;
   assign hd1       = (first_pkt && with_data) ? data_shift_ff : held_data_ff;
   assign rc1       = first_pkt ? COUNT_W'(1) : repeat_ff;
   assign pkt_match = (code_shift_ff == hc1) && (!with_data || (data_shift_ff == hd1));

   assign timer_tick = (timer_ff != TIMER_MAX) ? timer_ff + TIME_W'(1) : timer_ff;

   always_comb begin
      synced_in     = synced_ff;
      bit_cnt_in    = bit_cnt_ff;
      repeat_in     = repeat_ff;
      code_shift_in = code_shift_ff;
      data_shift_in = data_shift_ff;
      held_code_in  = held_code_ff;
      held_data_in  = held_data_ff;
      flag_code_in  = flag_code_ff;
      flag_data_in  = flag_data_ff;
      flag_learn_in = flag_learn_ff;
      timer_in      = timer_ff;
      rc2           = rc1;
      if (advance) begin
         case (in_op_ff)
            OP_PULSE: begin
               if (is_sync) begin
                  if (synced_ff) begin
                     if (bit_cnt_ff == CODE_END || with_data) begin
                        held_code_in = hc1;
                        held_data_in = hd1;
                        if (pkt_match) begin
                           rc2 = (rc1 != COUNT_MAX) ? rc1 + COUNT_W'(1) : rc1;
                        end else if (!with_data) begin
                           // code-only packet with a new code restarts the count
                           held_code_in = code_shift_ff;
                           rc2          = COUNT_W'(1);
                        end
                        repeat_in = rc2;
                        if (rc2 == COUNT_W'(2)) begin
                           flag_code_in = 1'b1;
                           flag_data_in = with_data;
                        end
                        if (rc2 == learn_ff) begin
                           flag_learn_in = 1'b1;
                        end
                        if (with_data) begin
                           data_shift_in = '0;
                        end
                     end else begin
                        data_shift_in = '0;
                     end
                     timer_in      = '0;
                     bit_cnt_in    = '0;
                     code_shift_in = '0;
                  end else begin
                     synced_in = 1'b1;
                  end
               end
               // the sync pair is also tried as a bit
               if (synced_in && (bit0 || bit1)) begin
                  if (bit_cnt_in < CODE_END) begin
                     code_shift_in = CODE_BITS'({code_shift_in, !bit0});
                  end else if (bit_cnt_in < FULL_END) begin
                     data_shift_in = DATA_BITS'({data_shift_in, !bit0});
                  end
                  bit_cnt_in = bit_cnt_in + COUNT_W'(1);
               end
            end
            OP_TICK: begin
               timer_in = timer_tick;
               if (timer_tick > timeout_ff && !flag_code_ff) begin
                  synced_in     = 1'b0;
                  bit_cnt_in    = '0;
                  repeat_in     = '0;
                  code_shift_in = '0;
                  data_shift_in = '0;
                  held_code_in  = '0;
               end
            end
            OP_ACK: begin
               flag_code_in  = 1'b0;
               flag_data_in  = 1'b0;
               flag_learn_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   assign held_code_ext = 32'(held_code_in);
   assign held_data_ext = 16'(held_data_in);

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         short_min_ff <= SHORT_MIN_RST;
         short_max_ff <= SHORT_MAX_RST;
         long_min_ff  <= LONG_MIN_RST;
         long_max_ff  <= LONG_MAX_RST;
         sync_min_ff  <= SYNC_MIN_RST;
         sync_max_ff  <= SYNC_MAX_RST;
         timeout_ff   <= REPEAT_TIMEOUT_RST;
         learn_ff     <= LEARN_REPEATS_RST;
      end else if (csr_we) begin
         case (csr_addr)
            REG_SHORT_MIN:      short_min_ff <= csr_wdata;
            REG_SHORT_MAX:      short_max_ff <= csr_wdata;
            REG_LONG_MIN:       long_min_ff  <= csr_wdata;
            REG_LONG_MAX:       long_max_ff  <= csr_wdata;
            REG_SYNC_MIN:       sync_min_ff  <= csr_wdata;
            REG_SYNC_MAX:       sync_max_ff  <= csr_wdata;
            REG_REPEAT_TIMEOUT: timeout_ff   <= csr_wdata;
            REG_LEARN_REPEATS:  learn_ff     <= csr_wdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff   <= req_tuser;
         in_high_ff <= req_tdata[TIME_W-1:0];
         in_low_ff  <= req_tdata[2*TIME_W-1:TIME_W];
      end
   end

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         synced_ff     <= 1'b0;
         bit_cnt_ff    <= '0;
         repeat_ff     <= '0;
         code_shift_ff <= '0;
         data_shift_ff <= '0;
         held_code_ff  <= '0;
         held_data_ff  <= '0;
         flag_code_ff  <= 1'b0;
         flag_data_ff  <= 1'b0;
         flag_learn_ff <= 1'b0;
         timer_ff      <= '0;
      end else begin
         synced_ff     <= synced_in;
         bit_cnt_ff    <= bit_cnt_in;
         repeat_ff     <= repeat_in;
         code_shift_ff <= code_shift_in;
         data_shift_ff <= data_shift_in;
         held_code_ff  <= held_code_in;
         held_data_ff  <= held_data_in;
         flag_code_ff  <= flag_code_in;
         flag_data_ff  <= flag_data_in;
         flag_learn_ff <= flag_learn_in;
         timer_ff      <= timer_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= {4'b0, synced_in, repeat_in, held_data_ext[DATA_OUT_W-1:0],
                         held_code_ext[CODE_OUT_W-1:0], flag_learn_in, flag_data_in,
                         flag_code_in};
      end
   end

   `RFPCD_ASSERT_NOW(a_code_needs_count, flag_code_ff, repeat_ff != '0,
      "code flag set with zero repeat count")
   `RFPCD_ASSERT_NOW(a_sync_drop_on_tick, synced_ff && !synced_in,
      advance && in_op_ff == OP_TICK, "sync lost outside a tick timeout")
   `RFPCD_ASSERT_NEXT(a_stage_moves, in_valid_ff && !out_valid_ff, out_valid_ff,
      "held request did not reach the response register")
   `RFPCD_ASSERT_NOW(a_bits_need_sync, bit_cnt_ff != bit_cnt_in, advance && synced_in
      || advance && in_op_ff == OP_TICK, "bit count moved without sync")

endmodule
